/* src/mf3_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared widths, register codes and types of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

	// Field widths fixed by the interface.
	localparam int PIXEL_W   = 8;
	localparam int ROW_W     = 16;
	localparam int OUT_COL_W = 10;
	localparam int IWIDTH_W  = 11;
	localparam int CFG_W     = 16;
	localparam int IDX_W     = 2;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// Register values after reset.
	localparam logic [IWIDTH_W-1:0] IMAGE_WIDTH_RESET  = 11'd1024;
	localparam logic [ROW_W-1:0]    IMAGE_HEIGHT_RESET = 16'd768;

	// Smallest usable frame dimension.
	localparam int MIN_DIM = 3;

	// Nine window pixels: 0..2 top row, 3..5 middle, 6..8 bottom; left to right.
	typedef logic [8:0][PIXEL_W-1:0] pixel_win_t;

	// Result description carried alongside the window.
	typedef struct packed {
		logic                 emit;
		logic                 last;
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
	} result_meta_t;

endpackage
`default_nettype wire

/* src/mf3_line_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_line_store
// One row of pixel storage: one write port and one read port with a
// registered read that updates only when enabled.
// ----------------------------------------------------------------------------
module mf3_line_store
	import mf3_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic      [PIXEL_W-1:0]         rd_data,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire logic [PIXEL_W-1:0]         wr_data
);

	logic [PIXEL_W-1:0] mem_q [DEPTH];
	logic [PIXEL_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds while the reader is stalled.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

/* src/mf3_median.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_median
// Median of nine pixels by a fixed network of nineteen compare-exchange cells.
// ----------------------------------------------------------------------------
module mf3_median
	import mf3_pkg::*;
(
	input  wire pixel_win_t         win,
	output logic [PIXEL_W-1:0]      med
);

	// Orders two entries so that the smaller one sits at index a.
	function automatic pixel_win_t cx(pixel_win_t v, logic [3:0] a, logic [3:0] b);
		pixel_win_t r;
		r = v;
		if (v[a] > v[b]) begin
			r[a] = v[b];
			r[b] = v[a];
		end
		return r;
	endfunction

	pixel_win_t p;

	// Partial sort that leaves the fifth smallest value at index four.
	always_comb begin
		p = win;
		p = cx(p, 4'd1, 4'd2);
		p = cx(p, 4'd4, 4'd5);
		p = cx(p, 4'd7, 4'd8);
		p = cx(p, 4'd0, 4'd1);
		p = cx(p, 4'd3, 4'd4);
		p = cx(p, 4'd6, 4'd7);
		p = cx(p, 4'd1, 4'd2);
		p = cx(p, 4'd4, 4'd5);
		p = cx(p, 4'd7, 4'd8);
		p = cx(p, 4'd0, 4'd3);
		p = cx(p, 4'd5, 4'd8);
		p = cx(p, 4'd4, 4'd7);
		p = cx(p, 4'd3, 4'd6);
		p = cx(p, 4'd1, 4'd4);
		p = cx(p, 4'd2, 4'd5);
		p = cx(p, 4'd4, 4'd7);
		p = cx(p, 4'd4, 4'd2);
		p = cx(p, 4'd6, 4'd4);
		p = cx(p, 4'd4, 4'd2);
	end

	assign med = p[4];

endmodule
`default_nettype wire

/* src/median_filter_3x3_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// median_filter_3x3_unit
// 3x3 median filter over a raster-order stream of 8-bit grayscale pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock cycle while results are taken, and gives one result
// for every pixel at row 2 or below and column 2 or beyond: the median of the
// neighbourhood centred one row up and one column left, with that centre's
// row, column and a flag on the last such result of the frame. A result is
// the median taken from the window register, which its pixel reaches through
// the stage one and line store read registers, and it waits in the result
// register until taken. Back-pressure on the result
// channel holds each stage only while the stage after it is full, so a
// waiting result stops the input once the two stages before it are occupied.
// The two line stores are memories of MAX_WIDTH bytes each, written and read
// once per pixel; they are not cleared after reset. A write to either
// configuration register restarts the frame at row zero, column zero and must
// be made while no pixel is in flight. Widths below 3 act as 3 and above
// MAX_WIDTH as MAX_WIDTH; heights below 3 act as 3.
// ----------------------------------------------------------------------------
module median_filter_3x3_unit
	import mf3_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Configuration writes.
	input  wire logic                   wr_en,
	input  wire logic [IDX_W-1:0]       wr_index,
	input  wire logic [CFG_W-1:0]       wr_data,
	// Pixel input channel.
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [PIXEL_W-1:0]     pixel,
	// Result channel.
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [PIXEL_W-1:0]          median,
	output logic [ROW_W-1:0]            out_row,
	output logic [OUT_COL_W-1:0]        out_col,
	output logic                        frame_last
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int EFF_W = $clog2(MAX_WIDTH + 1);

	// Configuration and position state.
	logic [IWIDTH_W-1:0]    image_width_q;
	logic [ROW_W-1:0]       image_height_q;
	logic [COL_W-1:0]       col_q;
	logic [ROW_W-1:0]       row_q;

	// First stage: accepted pixel and its position.
	logic                   valid_s1;
	logic [PIXEL_W-1:0]     px_s1;
	logic [COL_W-1:0]       col_s1;
	result_meta_t           meta_s1;

	// Second stage: window and result description.
	logic                   valid_s2;
	result_meta_t           meta_s2;
	pixel_win_t             win_q;

	// Result register.
	logic                   out_valid_q;
	logic [PIXEL_W-1:0]     median_q;
	logic [ROW_W-1:0]       out_row_q;
	logic [OUT_COL_W-1:0]   out_col_q;
	logic                   frame_last_q;

	logic [EFF_W-1:0]       width_eff;
	logic [ROW_W-1:0]       height_eff;
	logic [EFF_W-1:0]       col_inc;
	logic [ROW_W:0]         row_inc;
	logic                   col_wrap;
	logic                   row_wrap;
	logic                   in_xfer;
	logic                   out_free;
	logic                   s2_adv;
	logic                   s2_free;
	logic                   s1_adv;
	logic [PIXEL_W-1:0]     up_rd;
	logic [PIXEL_W-1:0]     mid_rd;
	logic [PIXEL_W-1:0]     med_w;

	// Effective frame dimensions after clamping.
	always_comb begin
		if (image_width_q < IWIDTH_W'(MIN_DIM)) begin
			width_eff = EFF_W'(MIN_DIM);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			width_eff = EFF_W'(MAX_WIDTH);
		end else begin
			width_eff = EFF_W'(image_width_q);
		end
		if (image_height_q < ROW_W'(MIN_DIM)) begin
			height_eff = ROW_W'(MIN_DIM);
		end else begin
			height_eff = image_height_q;
		end
	end

	// Position arithmetic for the pixel now at the input.
	assign col_inc  = EFF_W'(col_q) + EFF_W'(1);
	assign row_inc  = {1'b0, row_q} + (ROW_W + 1)'(1);
	assign col_wrap = (col_inc == width_eff);
	assign row_wrap = (row_inc == {1'b0, height_eff});

	// Flow control: each stage moves when the one after it has room.
	assign out_free = !out_valid_q || out_ready;
	assign s2_adv   = valid_s2 && (!meta_s2.emit || out_free);
	assign s2_free  = !valid_s2 || s2_adv;
	assign s1_adv   = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s1_adv;
	assign in_xfer  = in_valid && in_ready;

	// Configuration registers and raster counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RESET;
			image_height_q <= IMAGE_HEIGHT_RESET;
			col_q          <= '0;
			row_q          <= '0;
		end else if (wr_en && (wr_index == REG_IMAGE_WIDTH || wr_index == REG_IMAGE_HEIGHT)) begin
			if (wr_index == REG_IMAGE_WIDTH) begin
				image_width_q <= wr_data[IWIDTH_W-1:0];
			end else begin
				image_height_q <= wr_data[ROW_W-1:0];
			end
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	// Stage one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage one payload: pixel, store address and result description.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			px_s1        <= pixel;
			col_s1       <= col_q;
			meta_s1.emit <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
			meta_s1.last <= row_wrap && col_wrap;
			meta_s1.row  <= row_q - ROW_W'(1);
			meta_s1.col  <= OUT_COL_W'(col_q - COL_W'(1));
		end
	end

	// Line stores: the upper one takes the old middle row as the middle
	// one takes the new pixel, once the item leaves stage one.
	mf3_line_store #(
		.DEPTH   (MAX_WIDTH)
	) u_store_upper (
		.clk     (clk),
		.rd_en   (in_xfer),
		.rd_addr (col_q),
		.rd_data (up_rd),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (mid_rd)
	);

	mf3_line_store #(
		.DEPTH   (MAX_WIDTH)
	) u_store_middle (
		.clk     (clk),
		.rd_en   (in_xfer),
		.rd_addr (col_q),
		.rd_data (mid_rd),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (px_s1)
	);

	// Window shift and stage two control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			win_q    <= '0;
		end else begin
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (s1_adv) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= up_rd;
				win_q[3] <= win_q[4];
				win_q[4] <= win_q[5];
				win_q[5] <= mid_rd;
				win_q[6] <= win_q[7];
				win_q[7] <= win_q[8];
				win_q[8] <= px_s1;
			end
		end
	end

	// Stage two payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			meta_s2 <= meta_s1;
		end
	end

	// Sorting network over the current window.
	mf3_median u_median (
		.win (win_q),
		.med (med_w)
	);

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2 && meta_s2.emit;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (out_free && valid_s2 && meta_s2.emit) begin
			median_q     <= med_w;
			out_row_q    <= meta_s2.row;
			out_col_q    <= meta_s2.col;
			frame_last_q <= meta_s2.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign median     = median_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign frame_last = frame_last_q;

	// An accepted pixel occupies stage one in the next cycle.
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> valid_s1)
		else $error("accepted pixel did not reach stage one");

	// An item leaving stage one occupies stage two in the next cycle.
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> valid_s2)
		else $error("stage one item did not reach stage two");

	// An interior item in stage two reaches an empty result register at once.
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && meta_s2.emit && !out_valid_q) |=> out_valid_q)
		else $error("interior result was not registered");

	// Every result is centred below the top row of the frame.
	a_row_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_row_q != '0))
		else $error("result centred on the top row");

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the 3x3 median filter unit.
// ----------------------------------------------------------------------------
// Pixels stream in through a valid/ready channel over frames of changing size.
// A scoreboard keeps its own line stores, window and counters, predicts every
// filtered pixel and checks each result transfer against the oldest prediction.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb
	import mf3_pkg::*;
();

	localparam int unsigned RANDOM_ITEMS = 1450;
	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned SETTLE_READY = 8;

	// Indexes that decode to no register; writes there must leave the frame alone.
	localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic [PIXEL_W-1:0]   median;
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
		logic                 last;
	} filtered_px_t;

	// Predicts the filtered pixels of the stream and checks the block against them.
	class median_checker;
		localparam int unsigned LINE_DEPTH = 1024;

		logic [PIXEL_W-1:0]  upper_row [LINE_DEPTH];
		logic [PIXEL_W-1:0]  middle_row [LINE_DEPTH];
		logic [PIXEL_W-1:0]  nbhd [9];
		int unsigned         col_pos;
		int unsigned         row_pos;
		logic [IWIDTH_W-1:0] width_reg;
		logic [ROW_W-1:0]    height_reg;
		filtered_px_t        expected_medians [$];
		int unsigned         fail_count;

		function new();
			foreach (upper_row[i]) begin
				upper_row[i]  = '0;
				middle_row[i] = '0;
			end
			foreach (nbhd[i])
				nbhd[i] = '0;
			col_pos    = 0;
			row_pos    = 0;
			width_reg  = IMAGE_WIDTH_RESET;
			height_reg = IMAGE_HEIGHT_RESET;
			fail_count = 0;
		endfunction

		function void flag_failure(string msg);
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch: %s", msg);
		endfunction

		// A write to a real register restarts the frame; other indexes do nothing.
		function void write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_IMAGE_WIDTH: begin
					width_reg = data[IWIDTH_W-1:0];
					col_pos   = 0;
					row_pos   = 0;
				end
				REG_IMAGE_HEIGHT: begin
					height_reg = data[ROW_W-1:0];
					col_pos    = 0;
					row_pos    = 0;
				end
				default: ;
			endcase
		endfunction

		// Advances the filter state by one accepted pixel and queues any result.
		function void note_pixel(logic [PIXEL_W-1:0] px);
			int unsigned        w, h, c, r, j;
			logic [PIXEL_W-1:0] up, mid, t;
			logic [PIXEL_W-1:0] sorted [9];
			filtered_px_t       res;
			w = width_reg;
			if (w < MIN_DIM) w = MIN_DIM;
			if (w > LINE_DEPTH) w = LINE_DEPTH;
			h = height_reg;
			if (h < MIN_DIM) h = MIN_DIM;
			if (col_pos >= w) col_pos = 0;
			if (row_pos >= h) row_pos = 0;
			c = col_pos;
			r = row_pos;

			// The line stores move down one row in this column.
			up  = upper_row[c];
			mid = middle_row[c];
			upper_row[c]  = mid;
			middle_row[c] = px;

			// Window rows shift left; the new column enters on the right.
			for (int k = 0; k < 9; k += 3) begin
				nbhd[k]   = nbhd[k+1];
				nbhd[k+1] = nbhd[k+2];
			end
			nbhd[2] = up;
			nbhd[5] = mid;
			nbhd[8] = px;

			// Interior centres only: sort the nine and take the middle one.
			if (r >= 2 && c >= 2) begin
				sorted = nbhd;
				for (int i = 1; i < 9; i++) begin
					j = i;
					while (j > 0 && sorted[j] < sorted[j-1]) begin
						t           = sorted[j];
						sorted[j]   = sorted[j-1];
						sorted[j-1] = t;
						j--;
					end
				end
				res.median = sorted[4];
				res.row    = ROW_W'(r - 1);
				res.col    = OUT_COL_W'(c - 1);
				res.last   = (r == h - 1) && (c == w - 1);
				expected_medians.push_back(res);
			end

			if (c + 1 >= w) begin
				col_pos = 0;
				row_pos = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
			end
		endfunction

		function void check_median(filtered_px_t got);
			filtered_px_t want;
			if (expected_medians.size() == 0) begin
				flag_failure($sformatf("unexpected result median %0d row %0d col %0d last %0b",
					got.median, got.row, got.col, got.last));
				return;
			end
			want = expected_medians.pop_front();
			if (got.median !== want.median || got.row !== want.row ||
					got.col !== want.col || got.last !== want.last)
				flag_failure($sformatf({"expected median %0d row %0d col %0d last %0b, ",
					"got median %0d row %0d col %0d last %0b"},
					want.median, want.row, want.col, want.last,
					got.median, got.row, got.col, got.last));
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_index;
	logic [CFG_W-1:0]     wr_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [PIXEL_W-1:0]   pixel;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [PIXEL_W-1:0]   median;
	logic [ROW_W-1:0]     out_row;
	logic [OUT_COL_W-1:0] out_col;
	logic                 frame_last;

	median_checker sb;
	int unsigned   send_idle_pct = 9;
	int unsigned   recv_idle_pct = 78;
	bit            draining = 1'b0;

	median_filter_3x3_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.median     (median),
		.out_row    (out_row),
		.out_col    (out_col),
		.frame_last (frame_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: random back-pressure, and both transfers are observed here.
	always @(posedge clk) begin
		out_ready <= draining || ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && out_valid && out_ready)
			sb.check_median(filtered_px_t'({median, out_row, out_col, frame_last}));
		if (arst_n && in_valid && in_ready)
			sb.note_pixel(pixel);
	end

	// Offers one pixel after a random gap and returns at the edge of its transfer.
	task automatic send_pixel(input logic [PIXEL_W-1:0] px);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel    <= px;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Writes one register; the write takes effect at the next edge.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		sb.write_register(idx, data);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Stops sending, waits for every predicted result, then lets pixels that
	// give no result leave the pipeline.
	task automatic drain_pipeline();
		int unsigned ready_seen;
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_medians.size() != 0);
		draining   = 1'b1;
		ready_seen = 0;
		while (ready_seen < SETTLE_READY) begin
			@(posedge clk);
			if (out_ready) ready_seen++;
		end
		draining = 1'b0;
	endtask

	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		logic [PIXEL_W-1:0] opening_px [20] = '{
			8'd255, 8'd0, 8'd255, 8'd0,
			8'd255, 8'd0, 8'd255, 8'd255, 8'd0,
			8'd7, 8'd9,
			8'd12, 8'd200, 8'd45, 8'd255, 8'd0, 8'd133, 8'd255, 8'd1, 8'd77
		};
		int unsigned        random_sent, phase_no, w, h, frame, n_items, mode;
		logic [CFG_W-1:0]   w_data, h_data;
		logic [PIXEL_W-1:0] px;
		bit                 set_w, set_h, pause_mid;

		sb       = new();
		arst_n   = 1'b0;
		wr_en    = 1'b0;
		wr_index = '0;
		wr_data  = '0;
		in_valid = 1'b0;
		pixel    = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opening frames: width and height below the minimum both act as three.
		// A write to an unused index mid-frame must not restart it; a width
		// write with high bits set mid-frame must restart it.
		write_reg(REG_IMAGE_WIDTH, 16'd0);
		write_reg(REG_IMAGE_HEIGHT, 16'd1);
		foreach (opening_px[k]) begin
			if (k == 4) begin
				drain_pipeline();
				write_reg(REG_SPARE_2, 16'hFFFF);
				write_reg(REG_SPARE_3, 16'h5A5A);
			end
			if (k == 11) begin
				drain_pipeline();
				write_reg(REG_IMAGE_WIDTH, 16'hF803);
			end
			send_pixel(opening_px[k]);
		end
		drain_pipeline();

		// Random frames, mostly small, with a widest row and a tallest frame among them.
		random_sent = 0;
		phase_no    = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (random_sent < RANDOM_ITEMS / 3) begin
				send_idle_pct = 9;
				recv_idle_pct = 78;
			end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 78;
				recv_idle_pct = 9;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_w     = 1'b1;
			set_h     = 1'b1;
			pause_mid = (phase_no == 1) || ($urandom_range(5) == 0);

			if (phase_no == 4) begin
				// A width beyond the line stores acts as the full store width:
				// the first row runs out to the last store column and wraps.
				w_data  = {5'($urandom), 11'h7FF};
				h_data  = 16'd3;
				n_items = 1024 + 32;
			end else if (phase_no == 2) begin
				w_data  = 16'd3;
				h_data  = 16'hFFFF;
				n_items = 40;
			end else begin
				case ($urandom_range(9))
					0:       w = $urandom_range(2);
					1, 2:    w = $urandom_range(13, 64);
					default: w = $urandom_range(3, 12);
				endcase
				case ($urandom_range(9))
					0:       h = $urandom_range(2);
					1:       h = $urandom_range(7, 16);
					default: h = $urandom_range(3, 6);
				endcase
				w_data = {5'($urandom), 11'(w)};
				h_data = CFG_W'(h);
				// Sometimes only one register, sometimes neither; with neither the frame carries on.
				mode  = $urandom_range(5);
				set_w = (mode != 1) && (mode != 2);
				set_h = (mode != 0) && (mode != 2);
				frame = ((w < MIN_DIM) ? MIN_DIM : w) * ((h < MIN_DIM) ? MIN_DIM : h);
				n_items = ($urandom_range(2) == 0) ? frame : $urandom_range(1, 2 * frame);
				if (n_items > 400) n_items = 400;
			end
			random_sent += n_items;

			if ($urandom_range(7) == 0)
				write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_W'($urandom));
			if (set_w) write_reg(REG_IMAGE_WIDTH, w_data);
			if (set_h) write_reg(REG_IMAGE_HEIGHT, h_data);

			for (int k = 0; k < n_items; k++) begin
				case ($urandom_range(7))
					0:       px = '0;
					1:       px = '1;
					default: px = PIXEL_W'($urandom);
				endcase
				send_pixel(px);
				// Hold the stream mid-frame until every result is out.
				if (pause_mid && k == n_items / 2)
					drain_pipeline();
			end
			drain_pipeline();
			phase_no++;
		end

		if (sb.expected_medians.size() != 0)
			sb.flag_failure($sformatf("%0d results never arrived", sb.expected_medians.size()));
		if (sb.fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
